/* rtl/core/swrm_pkg.sv */
`default_nettype none

package swrm_pkg;

   // default stack depth
   localparam int unsigned STACK_DEPTH_DEF = 128;

   // field widths
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned OP_W     = 2;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned DEPTH_W  = 8;

   // stream widths (tdata padded to whole bytes)
   localparam int unsigned REQ_TDATA_W = 32;
   localparam int unsigned RSP_TDATA_W = 48;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUSH       = 2'd0;
   localparam logic [OP_W-1:0] OP_POP        = 2'd1;
   localparam logic [OP_W-1:0] OP_PEEK       = 2'd2;
   localparam logic [OP_W-1:0] OP_REMOVE_MAX = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

   // returned on an empty stack
   localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;

endpackage

`default_nettype wire

/* rtl/core/stack_with_remove_max_core.sv */
`default_nettype none
// Push (stored, or dropped on a full stack) and any other request on an empty stack:
// the result register is loaded straight from the accepted request.
// Pop and peek: the top entry is read through the registered read port of the entry store.
// Remove-max: the scan reads one stored entry per cycle from the bottom up; then one read
// and one write per cycle move the entries above the maximum down to close the gap.
// One request at a time; the next is taken once the result register is free or draining.
// Reset (synchronous, active high) empties the stack; stored words stay undefined.
module stack_with_remove_max_core #(
   parameter int unsigned STACK_DEPTH = swrm_pkg::STACK_DEPTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [31:0] push_value
   input  wire logic [swrm_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [1:0] operation
   input  wire logic [swrm_pkg::OP_W-1:0]           req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [31:0] data_out, [39:32] depth_used, [40] is_empty, [41] is_full, [47:42] zero
   output logic      [swrm_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // [1:0] status
   output logic      [swrm_pkg::STATUS_W-1:0]       rsp_tuser
);

   localparam int unsigned AW = $clog2(STACK_DEPTH);
   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
   localparam int unsigned PAD_W = swrm_pkg::RSP_TDATA_W - swrm_pkg::WORD_W
                                   - swrm_pkg::DEPTH_W - 2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_SCAN,
      S_SHIFT
   } state_type;

   state_type state_ff, state_in;

   logic [CW-1:0]                     count_ff, count_in;
   logic [CW-1:0]                     idx_ff, idx_in;
   logic [CW-1:0]                     best_idx_ff, best_idx_in;
   logic signed [swrm_pkg::WORD_W-1:0] best_val_ff, best_val_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [swrm_pkg::WORD_W-1:0]       rsp_data_ff, rsp_data_in;
   logic [swrm_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [swrm_pkg::DEPTH_W-1:0]      rsp_depth_ff, rsp_depth_in;
   logic                              rsp_empty_ff, rsp_empty_in;
   logic                              rsp_full_ff, rsp_full_in;

   // store port signals
   logic                              ram_we;
   logic [AW-1:0]                     ram_waddr;
   logic [swrm_pkg::WORD_W-1:0]       ram_wdata;
   logic [AW-1:0]                     ram_raddr;
   logic [swrm_pkg::WORD_W-1:0]       ram_rdata;

   // result load
   logic                              ld_en;
   logic [swrm_pkg::WORD_W-1:0]       ld_data;
   logic [swrm_pkg::STATUS_W-1:0]     ld_status;
   logic [CW-1:0]                     ld_count;
   logic [CW+7:0]                     ld_count_wide;

   logic                              req_accept;
   logic [CW-1:0]                     cnt_m1;
   logic [CW-1:0]                     idx_p1;
   logic [CW-1:0]                     idx_p2;
   logic                              take;
   logic signed [swrm_pkg::WORD_W-1:0] best_val_nx;
   logic [CW-1:0]                     best_idx_nx;
   logic [CW-1:0]                     best_p1;

   swrm_ram #(
      .DEPTH   (STACK_DEPTH),
      .AW      (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   assign cnt_m1 = count_ff - CW'(1);
   assign idx_p1 = idx_ff + CW'(1);
   assign idx_p2 = idx_ff + CW'(2);

   // running maximum; strict compare keeps the oldest of equal values
   assign take        = (idx_ff == '0) || ($signed(ram_rdata) > best_val_ff);
   assign best_val_nx = take ? $signed(ram_rdata) : best_val_ff;
   assign best_idx_nx = take ? idx_ff : best_idx_ff;
   assign best_p1     = best_idx_nx + CW'(1);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      best_val_in = best_val_ff;
      best_idx_in = best_idx_ff;
      ram_we      = 1'b0;
      ram_waddr   = '0;
      ram_wdata   = '0;
      ram_raddr   = '0;
      ld_en       = 1'b0;
      ld_data     = '0;
      ld_status   = swrm_pkg::ST_OK;
      ld_count    = count_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_tuser == swrm_pkg::OP_PUSH) begin
                  if (count_ff == CW'(STACK_DEPTH)) begin
                     ld_en     = 1'b1;
                     ld_status = swrm_pkg::ST_OVERFLOW;
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = count_ff[AW-1:0];
                     ram_wdata = req_tdata[swrm_pkg::WORD_W-1:0];
                     count_in  = count_ff + CW'(1);
                     ld_en     = 1'b1;
                     ld_count  = count_ff + CW'(1);
                  end
               end else if (count_ff == '0) begin
                  ld_en     = 1'b1;
                  ld_data   = swrm_pkg::WORD_MIN;
                  ld_status = swrm_pkg::ST_EMPTY;
               end else if (req_tuser == swrm_pkg::OP_POP) begin
                  ram_raddr = cnt_m1[AW-1:0];
                  count_in  = cnt_m1;
                  state_in  = S_READ;
               end else if (req_tuser == swrm_pkg::OP_PEEK) begin
                  ram_raddr = cnt_m1[AW-1:0];
                  state_in  = S_READ;
               end else begin
                  // remove-max: start the scan at the bottom
                  ram_raddr = '0;
                  idx_in    = '0;
                  state_in  = S_SCAN;
               end
            end
         end

         S_READ: begin
            ld_en    = 1'b1;
            ld_data  = ram_rdata;
            state_in = S_IDLE;
         end

         S_SCAN: begin
            best_val_in = best_val_nx;
            best_idx_in = best_idx_nx;
            if (idx_ff == cnt_m1) begin
               if (best_idx_nx == cnt_m1) begin
                  // maximum on top: nothing to shift
                  count_in = cnt_m1;
                  ld_en    = 1'b1;
                  ld_data  = best_val_nx;
                  ld_count = cnt_m1;
                  state_in = S_IDLE;
               end else begin
                  ram_raddr = best_p1[AW-1:0];
                  idx_in    = best_idx_nx;
                  state_in  = S_SHIFT;
               end
            end else begin
               ram_raddr = idx_p1[AW-1:0];
               idx_in    = idx_p1;
            end
         end

         S_SHIFT: begin
            // move entry idx+1 down into idx
            ram_we    = 1'b1;
            ram_waddr = idx_ff[AW-1:0];
            ram_wdata = ram_rdata;
            if (idx_p1 == cnt_m1) begin
               count_in = cnt_m1;
               ld_en    = 1'b1;
               ld_data  = best_val_ff;
               ld_count = cnt_m1;
               state_in = S_IDLE;
            end else begin
               ram_raddr = idx_p2[AW-1:0];
               idx_in    = idx_p1;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result register
   assign ld_count_wide = {8'd0, ld_count};

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_full_in   = rsp_full_ff;
      if (ld_en) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = ld_data;
         rsp_status_in = ld_status;
         rsp_depth_in  = ld_count_wide[7:0];
         rsp_empty_in  = (ld_count == '0);
         rsp_full_in   = (ld_count == CW'(STACK_DEPTH));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      best_idx_ff   <= best_idx_in;
      best_val_ff   <= best_val_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_full_ff   <= rsp_full_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_full_ff, rsp_empty_ff, rsp_depth_ff, rsp_data_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

/* rtl/core/swrm_ram.sv */
`default_nettype none

// Entry store: one write port, one read port, registered read data.
module swrm_ram #(
   parameter int unsigned DEPTH = swrm_pkg::STACK_DEPTH_DEF,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [AW-1:0]                 wr_addr,
   input  wire logic [swrm_pkg::WORD_W-1:0]   wr_data,
   input  wire logic [AW-1:0]                 rd_addr,
   output logic      [swrm_pkg::WORD_W-1:0]   rd_data
);

   logic [swrm_pkg::WORD_W-1:0] mem_ff [DEPTH];
   logic [swrm_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
